FILE: hdl/byte_ring_fifo_with_line_find_macros.svh
// ============================================================================
// Assertion macros for the byte ring FIFO.
// Each check is active in simulation and compiles to nothing for synthesis.
// ============================================================================
`ifndef BYTE_RING_FIFO_WITH_LINE_FIND_MACROS_SVH
`define BYTE_RING_FIFO_WITH_LINE_FIND_MACROS_SVH
`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define BRF_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");
// Consequent must hold in the same cycle as the antecedent.
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
// Consequent must hold in the cycle after the antecedent.
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define BRF_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/brf_pkg.sv
// ============================================================================
// brf_pkg: shared types and constants
// Opcodes, internal command kinds, command and result words, index wrap.
// ============================================================================
package brf_pkg;

    // Opcodes as they arrive on the input channel.
    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_DISCARD = 3'd3;
    localparam logic [2:0] OP_FIND    = 3'd4;

    // Command kinds after classification by the front end.
    localparam logic [2:0] KIND_NOP     = 3'd0;
    localparam logic [2:0] KIND_PUSH    = 3'd1;
    localparam logic [2:0] KIND_POP     = 3'd2;
    localparam logic [2:0] KIND_PEEK    = 3'd3;
    localparam logic [2:0] KIND_DISCARD = 3'd4;
    localparam logic [2:0] KIND_FIND    = 3'd5;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [8:0] CAP_RESET    = 9'd256;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [8:0] count;
    } cmd_t;

    typedef struct packed {
        logic [8:0] amount;
        logic [7:0] byte_out;
        logic [8:0] fill_level;
        logic       is_empty;
        logic       is_full;
    } result_t;

    // Index plus step, modulo the capacity; the sum stays below
    // twice the capacity, so one compare and subtract is enough.
    function automatic logic [8:0] wrap_add(input logic [8:0] idx,
                                            input logic [8:0] step,
                                            input logic [8:0] cap);
        logic [9:0] sum;
        sum = {1'b0, idx} + {1'b0, step};
        if (sum >= {1'b0, cap})
        begin
            sum = sum - {1'b0, cap};
        end
        return sum[8:0];
    endfunction

endpackage

FILE: hdl/brf_front.sv
// ============================================================================
// brf_front: input stage
// Registers each accepted word and turns its opcode into a command kind.
// ============================================================================
module brf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    opcode,
    input  logic [7:0]    data_in,
    input  logic [8:0]    count_or_offset,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output brf_pkg::cmd_t cmd
);
    import brf_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;

    // The stage takes a word whenever it is empty or drains this cycle.
    assign in_ready = !valid_reg || cmd_ready;
    assign accept   = in_valid && in_ready;

    // Classify the opcode; unused codes become a no-op.
    always_comb
    begin
        cmd_next       = cmd_reg;
        valid_next     = valid_reg && !cmd_ready;
        if (accept)
        begin
            valid_next     = 1'b1;
            cmd_next.data  = data_in;
            cmd_next.count = count_or_offset;
            case (opcode)
                OP_PUSH:    cmd_next.kind = KIND_PUSH;
                OP_POP:     cmd_next.kind = KIND_POP;
                OP_PEEK:    cmd_next.kind = KIND_PEEK;
                OP_DISCARD: cmd_next.kind = KIND_DISCARD;
                OP_FIND:    cmd_next.kind = KIND_FIND;
                default:    cmd_next.kind = KIND_NOP;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

FILE: hdl/brf_cmdq.sv
// ============================================================================
// brf_cmdq: command queue
// Two-entry queue that decouples the input stage from the execution unit.
// ============================================================================
module brf_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  brf_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output brf_pkg::cmd_t pop_cmd
);
    import brf_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_en;
    logic       rd_en;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign wr_en      = push_valid && push_ready;
    assign rd_en      = pop_valid && pop_ready;

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hdl/brf_back.sv
// ============================================================================
// brf_back: execution unit
// Holds the byte store, indices and fill count, runs each command and
// scans the store one byte per cycle for a line search.
// ============================================================================
`include "byte_ring_fifo_with_line_find_macros.svh"

module brf_back #(
    parameter int DEPTH = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [8:0]       cfg_data,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  brf_pkg::cmd_t    cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output brf_pkg::result_t res
);
    import brf_pkg::*;

    // The capacity field is 9 bits, so at most 511 entries are ever used.
    localparam int         CAP_MAX   = (DEPTH < 511) ? DEPTH : 511;
    localparam int         AW        = $clog2(CAP_MAX);
    localparam logic [8:0] CAP_MAX_C = 9'(CAP_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_FIND = 2'd2;

    logic [7:0]    mem [CAP_MAX];

    logic [1:0]    state_reg,  state_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [AW-1:0] scan_reg,   scan_next;
    logic [8:0]    fill_reg,   fill_next;
    logic [8:0]    cap_reg,    cap_next;
    logic [8:0]    pos_reg,    pos_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg,    out_next;
    logic [7:0]    rd_data_reg;

    logic          out_free;
    logic          take;
    logic [8:0]    cap_use;
    logic [8:0]    rd9;
    logic [8:0]    wr9;
    logic [8:0]    amt_c;
    logic [8:0]    pos_inc;
    logic          imm;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    function automatic result_t make_result(input logic [8:0] amt,
                                            input logic [7:0] byt,
                                            input logic [8:0] fill,
                                            input logic [8:0] cap);
        result_t r;
        r.amount     = amt;
        r.byte_out   = byt;
        r.fill_level = fill;
        r.is_empty   = (fill == 9'd0);
        r.is_full    = (fill >= cap);
        return r;
    endfunction

    // Capacity in use: zero acts as one, large values saturate.
    always_comb
    begin
        if (cap_reg == 9'd0)
        begin
            cap_use = 9'd1;
        end
        else if (cap_reg > CAP_MAX_C)
        begin
            cap_use = CAP_MAX_C;
        end
        else
        begin
            cap_use = cap_reg;
        end
    end

    assign rd9       = 9'(rd_idx_reg);
    assign wr9       = 9'(wr_idx_reg);
    assign pos_inc   = pos_reg + 9'd1;
    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign take      = cmd_valid && cmd_ready;

    // Command execution and line scan.
    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        scan_next      = scan_reg;
        fill_next      = fill_reg;
        cap_next       = cap_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        mem_we         = 1'b0;
        mem_wa         = wr_idx_reg;
        mem_wd         = cmd.data;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg;
        amt_c          = 9'd0;
        imm            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    imm = 1'b1;
                    case (cmd.kind)
                        KIND_PUSH:
                        begin
                            if (fill_reg < cap_use)
                            begin
                                mem_we      = 1'b1;
                                wr_idx_next = AW'(wrap_add(wr9, 9'd1, cap_use));
                                fill_next   = fill_reg + 9'd1;
                                amt_c       = 9'd1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (fill_reg != 9'd0)
                            begin
                                rd_en       = 1'b1;
                                rd_idx_next = AW'(wrap_add(rd9, 9'd1, cap_use));
                                fill_next   = fill_reg - 9'd1;
                                state_next  = ST_READ;
                                imm         = 1'b0;
                            end
                        end
                        KIND_PEEK:
                        begin
                            if (cmd.count < fill_reg)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(wrap_add(rd9, cmd.count, cap_use));
                                state_next = ST_READ;
                                imm        = 1'b0;
                            end
                        end
                        KIND_DISCARD:
                        begin
                            amt_c       = (cmd.count < fill_reg) ? cmd.count : fill_reg;
                            rd_idx_next = AW'(wrap_add(rd9, amt_c, cap_use));
                            fill_next   = fill_reg - amt_c;
                        end
                        KIND_FIND:
                        begin
                            if (fill_reg != 9'd0)
                            begin
                                rd_en      = 1'b1;
                                scan_next  = AW'(wrap_add(rd9, 9'd1, cap_use));
                                pos_next   = 9'd0;
                                state_next = ST_FIND;
                                imm        = 1'b0;
                            end
                        end
                        default:
                        begin
                            amt_c = 9'd0;
                        end
                    endcase
                    if (imm)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = make_result(amt_c, 8'd0, fill_next, cap_use);
                    end
                end
            end
            ST_READ:
            begin
                // Byte from pop or peek arrives from the store this cycle.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = make_result(9'd1, rd_data_reg, fill_reg, cap_use);
                    state_next     = ST_IDLE;
                end
            end
            ST_FIND:
            begin
                // Check the byte at pos_reg while fetching the next one.
                if (out_free)
                begin
                    if (rd_data_reg == NEWLINE_BYTE)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = make_result(pos_inc, 8'd0, fill_reg, cap_use);
                        state_next     = ST_IDLE;
                    end
                    else if (pos_inc == fill_reg)
                    begin
                        amt_c          = (fill_reg >= cap_use) ? cap_use : 9'd0;
                        out_valid_next = 1'b1;
                        out_next       = make_result(amt_c, 8'd0, fill_reg, cap_use);
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = scan_reg;
                        scan_next = AW'(wrap_add(9'(scan_reg), 9'd1, cap_use));
                        pos_next  = pos_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A capacity write empties the queue.
        if (cfg_we)
        begin
            cap_next    = cfg_data;
            wr_idx_next = '0;
            rd_idx_next = '0;
            fill_next   = 9'd0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            fill_reg      <= 9'd0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            fill_reg      <= fill_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Scan position and result word.
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        pos_reg  <= pos_next;
        out_reg  <= out_next;
    end

    // Byte store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    `BRF_ASSERT_ALWAYS(a_fill_within_cap, clk, rst_n, fill_reg <= cap_use)
    `BRF_ASSERT_ALWAYS(a_index_track, clk, rst_n, wr9 == wrap_add(rd9, fill_reg, cap_use))
    `BRF_ASSERT_IMP(a_scan_bound, clk, rst_n, state_reg == ST_FIND, pos_reg < fill_reg)
    `BRF_ASSERT_NEXT(a_pop_reads, clk, rst_n,
        take && cmd.kind == KIND_POP && fill_reg != 9'd0, state_reg == ST_READ)

endmodule

FILE: hdl/byte_ring_fifo_with_line_find.sv
// ============================================================================
// byte_ring_fifo_with_line_find: circular byte FIFO with line search.
// Push/discard 1 per cycle while the output is not stalled; pop and peek (store
// read) and find-line each finish before the next command is taken.
// Reset clears indices and fill count, sets capacity 256; the store keeps no reset.
// ============================================================================
module byte_ring_fifo_with_line_find #(
    parameter int DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] opcode,
    input  logic [7:0] data_in,
    input  logic [8:0] count_or_offset,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [8:0] amount,
    output logic [7:0] byte_out,
    output logic [8:0] fill_level,
    output logic       is_empty,
    output logic       is_full
);
    import brf_pkg::*;

    logic    fr_valid;
    logic    fr_ready;
    cmd_t    fr_cmd;
    logic    q_valid;
    logic    q_ready;
    cmd_t    q_cmd;
    result_t res;

    // Front end: accept and classify.
    brf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .data_in         (data_in),
        .count_or_offset (count_or_offset),
        .cmd_valid       (fr_valid),
        .cmd_ready       (fr_ready),
        .cmd             (fr_cmd)
    );

    // Queue between front end and execution unit.
    brf_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_cmd   (fr_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // Execution unit with the byte store.
    brf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign amount     = res.amount;
    assign byte_out   = res.byte_out;
    assign fill_level = res.fill_level;
    assign is_empty   = res.is_empty;
    assign is_full    = res.is_full;

endmodule

FILE: test/tb_top.sv
// ============================================================================
// tb_top: testbench for the byte ring FIFO with line search
// A driver feeds opcode words from a backlog, and a monitor predicts each
// result from its own copy of the ring and compares every field. The run
// covers directed corner cases, then random phases at several capacities,
// with random idling on both sides, a long output hold and drains between
// capacity writes.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import brf_pkg::*;

    localparam int RING_SLOTS   = 256;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_GAP    = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 40;

    // Opcodes that the block treats as no-ops.
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic [8:0] cnt;
    } fifo_cmd_t;

    logic       clk             = 1'b0;
    logic       rst_n           = 1'b0;
    logic       cfg_we          = 1'b0;
    logic [8:0] cfg_data        = '0;
    logic       in_valid        = 1'b0;
    logic       in_ready;
    logic [2:0] opcode          = '0;
    logic [7:0] data_in         = '0;
    logic [8:0] count_or_offset = '0;
    logic       out_valid;
    logic       out_ready       = 1'b0;
    logic [8:0] amount;
    logic [7:0] byte_out;
    logic [8:0] fill_level;
    logic       is_empty;
    logic       is_full;

    // Stimulus bookkeeping.
    fifo_cmd_t op_backlog[$];
    fifo_cmd_t next_cmd;
    int        queued_count   = 0;
    int        accepted_count = 0;
    int        tx_idle_pct    = 33;
    int        rx_idle_pct    = 33;
    int        cycle_count    = 0;
    int        mismatch_count = 0;
    logic      hold_req       = 1'b0;
    logic      hold_seen      = 1'b0;
    int        hold_left      = 0;

    // Predicted ring contents and the results still owed by the block.
    logic [7:0] ring_mem [RING_SLOTS];
    int         head_idx   = 0;
    int         tail_idx   = 0;
    int         held_bytes = 0;
    logic [8:0] cap_reg    = CAP_RESET;
    result_t    outcome_q[$];
    result_t    got_word;
    result_t    want_word;

    byte_ring_fifo_with_line_find dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .data_in         (data_in),
        .count_or_offset (count_or_offset),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .amount          (amount),
        .byte_out        (byte_out),
        .fill_level      (fill_level),
        .is_empty        (is_empty),
        .is_full         (is_full)
    );

    always #4 clk = ~clk;

    // Capacity actually in use for a register value.
    function automatic int cap_limit(input logic [8:0] value);
        if (value == 9'd0)
        begin
            return 1;
        end
        if (value > RING_SLOTS)
        begin
            return RING_SLOTS;
        end
        return int'(value);
    endfunction

    // Apply one opcode word to the predicted ring and return its result.
    function automatic result_t fifo_op_outcome(input logic [2:0] op,
                                                input logic [7:0] data,
                                                input logic [8:0] cnt);
        result_t r;
        int      cap;
        int      n;
        int      i;
        logic    found;
        cap   = cap_limit(cap_reg);
        n     = int'(cnt);
        r     = '0;
        found = 1'b0;
        case (op)
            OP_PUSH:
            begin
                if (held_bytes < cap)
                begin
                    ring_mem[tail_idx] = data;
                    tail_idx           = (tail_idx + 1) % cap;
                    held_bytes         = held_bytes + 1;
                    r.amount           = 9'd1;
                end
            end
            OP_POP:
            begin
                if (held_bytes > 0)
                begin
                    r.byte_out = ring_mem[head_idx];
                    head_idx   = (head_idx + 1) % cap;
                    held_bytes = held_bytes - 1;
                    r.amount   = 9'd1;
                end
            end
            OP_PEEK:
            begin
                if (n < held_bytes)
                begin
                    r.byte_out = ring_mem[(head_idx + n) % cap];
                    r.amount   = 9'd1;
                end
            end
            OP_DISCARD:
            begin
                if (n > held_bytes)
                begin
                    n = held_bytes;
                end
                head_idx   = (head_idx + n) % cap;
                held_bytes = held_bytes - n;
                r.amount   = 9'(n);
            end
            OP_FIND:
            begin
                for (i = 0; i < held_bytes && !found; i++)
                begin
                    if (ring_mem[(head_idx + i) % cap] == NEWLINE_BYTE)
                    begin
                        r.amount = 9'(i + 1);
                        found    = 1'b1;
                    end
                end
                // A full ring with no newline reports its whole capacity.
                if (!found && held_bytes > 0 && held_bytes >= cap)
                begin
                    r.amount = 9'(cap);
                end
            end
            default:
            begin
            end
        endcase
        r.fill_level = 9'(held_bytes);
        r.is_empty   = (held_bytes == 0);
        r.is_full    = (held_bytes >= cap);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatch_count < REPORT_MAX)
        begin
            $display("mismatch at cycle %0d: %s got %0d want %0d",
                     cycle_count, field, got, want);
        end
        mismatch_count++;
    endtask

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("TB_ERROR");
        $finish;
    end

    // Driver: offers the next word from the backlog, idling at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (op_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                next_cmd        = op_backlog.pop_front();
                in_valid        <= 1'b1;
                opcode          <= next_cmd.op;
                data_in         <= next_cmd.data;
                count_or_offset <= next_cmd.cnt;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold whenever one is requested.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: tracks capacity writes, predicts accepted words, checks results.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            head_idx   = 0;
            tail_idx   = 0;
            held_bytes = 0;
            cap_reg    = CAP_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg    = cfg_data;
                head_idx   = 0;
                tail_idx   = 0;
                held_bytes = 0;
            end
            if (in_valid && in_ready)
            begin
                outcome_q.push_back(fifo_op_outcome(opcode, data_in, count_or_offset));
                accepted_count++;
            end
            if (out_valid && out_ready)
            begin
                got_word = '{amount, byte_out, fill_level, is_empty, is_full};
                if (outcome_q.size() == 0)
                begin
                    report_mismatch("unexpected word, amount", int'(amount), 0);
                end
                else
                begin
                    want_word = outcome_q.pop_front();
                    if (got_word.amount !== want_word.amount)
                    begin
                        report_mismatch("amount", int'(got_word.amount),
                                        int'(want_word.amount));
                    end
                    if (got_word.byte_out !== want_word.byte_out)
                    begin
                        report_mismatch("byte_out", int'(got_word.byte_out),
                                        int'(want_word.byte_out));
                    end
                    if (got_word.fill_level !== want_word.fill_level)
                    begin
                        report_mismatch("fill_level", int'(got_word.fill_level),
                                        int'(want_word.fill_level));
                    end
                    if (got_word.is_empty !== want_word.is_empty)
                    begin
                        report_mismatch("is_empty", int'(got_word.is_empty),
                                        int'(want_word.is_empty));
                    end
                    if (got_word.is_full !== want_word.is_full)
                    begin
                        report_mismatch("is_full", int'(got_word.is_full),
                                        int'(want_word.is_full));
                    end
                end
            end
        end
    end

    task automatic queue_op(input logic [2:0] op, input logic [7:0] data,
                            input logic [8:0] cnt);
        fifo_cmd_t c;
        c.op   = op;
        c.data = data;
        c.cnt  = cnt;
        op_backlog.push_back(c);
        queued_count++;
    endtask

    // Any byte except the newline.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == NEWLINE_BYTE)
        begin
            b = 8'hFF;
        end
        return b;
    endfunction

    function automatic logic [8:0] any_count();
        return 9'($urandom_range(0, 511));
    endfunction

    // Wait until every queued word was accepted and answered, then let the
    // pipeline settle.
    task automatic wait_drained();
        while (accepted_count != queued_count || outcome_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [8:0] value);
        wait_drained();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Random traffic: whole lines that get searched and consumed, mixed with
    // single operations of every kind.
    task automatic random_mix(input int n, input int cap);
        int start;
        int pick;
        int len;
        int k;
        start = queued_count;
        while (queued_count - start < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                len = $urandom_range(0, (cap > 13) ? 12 : cap - 1);
                for (k = 0; k < len; k++)
                begin
                    queue_op(OP_PUSH, plain_byte(), any_count());
                end
                queue_op(OP_PUSH, NEWLINE_BYTE, any_count());
                queue_op(OP_FIND, 8'($urandom_range(0, 255)), any_count());
                if ($urandom_range(0, 1) == 0)
                begin
                    queue_op(OP_DISCARD, 8'($urandom_range(0, 255)), 9'(len + 1));
                end
                else
                begin
                    for (k = 0; k <= len; k++)
                    begin
                        queue_op(OP_POP, 8'($urandom_range(0, 255)), any_count());
                    end
                end
            end
            else if (pick < 55)
            begin
                queue_op(OP_PUSH, ($urandom_range(0, 4) == 0) ? NEWLINE_BYTE
                         : 8'($urandom_range(0, 255)), any_count());
            end
            else if (pick < 67)
            begin
                queue_op(OP_POP, 8'($urandom_range(0, 255)), any_count());
            end
            else if (pick < 79)
            begin
                queue_op(OP_PEEK, 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 4) == 0) ? any_count()
                         : 9'($urandom_range(0, cap)));
            end
            else if (pick < 87)
            begin
                queue_op(OP_DISCARD, 8'($urandom_range(0, 255)),
                         ($urandom_range(0, 9) == 0) ? any_count()
                         : 9'($urandom_range(0, 4)));
            end
            else if (pick < 96)
            begin
                queue_op(OP_FIND, 8'($urandom_range(0, 255)), any_count());
            end
            else
            begin
                queue_op(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)),
                         8'($urandom_range(0, 255)), any_count());
            end
        end
    endtask

    task automatic run_phase(input logic [8:0] cap_value, input int n,
                             input int tx_pct, input int rx_pct, input logic long_hold);
        set_capacity(cap_value);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (long_hold)
        begin
            hold_req = ~hold_req;
        end
        random_mix(n, cap_limit(cap_value));
    endtask

    // Stimulus sequence.
    initial
    begin
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring at the reset capacity, then a short line.
        queue_op(OP_POP, 8'h00, 9'd0);
        queue_op(OP_PEEK, 8'h00, 9'd0);
        queue_op(OP_DISCARD, 8'hFF, 9'd511);
        queue_op(OP_FIND, 8'h00, 9'd0);
        queue_op(OP_LAST_UNUSED, 8'hFF, 9'd511);
        queue_op(OP_FIRST_UNUSED, 8'h00, 9'd0);
        queue_op(OP_PUSH, 8'h00, 9'd0);
        queue_op(OP_PUSH, 8'hFF, 9'd511);
        queue_op(OP_PUSH, NEWLINE_BYTE, 9'd0);
        queue_op(OP_PUSH, 8'h41, 9'd0);
        queue_op(OP_PEEK, 8'h00, 9'd0);
        queue_op(OP_PEEK, 8'h00, 9'd3);
        queue_op(OP_PEEK, 8'h00, 9'd4);
        queue_op(OP_FIND, 8'h00, 9'd0);
        queue_op(OP_POP, 8'h00, 9'd0);
        queue_op(OP_DISCARD, 8'h00, 9'd0);
        queue_op(OP_DISCARD, 8'h00, 9'd256);

        // Small ring: full without a newline, push when full, wrap-around.
        set_capacity(9'd4);
        queue_op(OP_PUSH, 8'h61, 9'd0);
        queue_op(OP_PUSH, 8'h62, 9'd0);
        queue_op(OP_PUSH, 8'h63, 9'd0);
        queue_op(OP_PUSH, 8'h64, 9'd0);
        queue_op(OP_FIND, 8'h00, 9'd0);
        queue_op(OP_PUSH, NEWLINE_BYTE, 9'd0);
        queue_op(OP_POP, 8'h00, 9'd0);
        queue_op(OP_PUSH, NEWLINE_BYTE, 9'd0);
        queue_op(OP_FIND, 8'h00, 9'd0);

        // Random phases over a range of capacities, extremes included.
        run_phase(9'd1, 60, 33, 33, 1'b0);
        run_phase(9'd0, 60, 33, 33, 1'b0);
        run_phase(9'd2, 80, 33, 33, 1'b0);
        run_phase(9'd511, 150, 0, 0, 1'b0);
        run_phase(9'd3, 80, 33, 33, 1'b1);
        run_phase(9'd257, 60, 33, 33, 1'b0);
        run_phase(9'd17, 100, 33, 33, 1'b0);
        run_phase(9'($urandom_range(5, 64)), 100, 33, 33, 1'b0);

        // Largest ring filled to the top with no newline, then random traffic.
        set_capacity(9'd256);
        hold_req = ~hold_req;
        for (k = 0; k < RING_SLOTS; k++)
        begin
            queue_op(OP_PUSH, plain_byte(), any_count());
        end
        queue_op(OP_PUSH, NEWLINE_BYTE, 9'd0);
        queue_op(OP_FIND, 8'h00, 9'd0);
        queue_op(OP_PEEK, 8'h00, 9'd255);
        queue_op(OP_PEEK, 8'h00, 9'd256);
        queue_op(OP_DISCARD, 8'h00, 9'd200);
        random_mix(80, RING_SLOTS);

        run_phase(9'd8, 80, 33, 33, 1'b0);
        run_phase(9'($urandom_range(1, 300)), 100, 33, 33, 1'b0);

        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/brf_pkg.sv
hdl/brf_front.sv
hdl/brf_cmdq.sv
hdl/brf_back.sv
hdl/byte_ring_fifo_with_line_find.sv
test/tb_top.sv
